>>> rtl/core/cfgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfgl_pkg;

  // Pixel arithmetic: wide enough for every intermediate, wraps to 12 bits on output
  typedef logic signed [13:0] pix_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned STEP_W     = 5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_TWELVE_HOUR   = 3'd2,
    REG_LARGE_WIDTH   = 3'd3,
    REG_LARGE_HEIGHT  = 3'd4,
    REG_LARGE_DESCENT = 3'd5,
    REG_SMALL_WIDTH   = 3'd6,
    REG_SMALL_HEIGHT  = 3'd7
  } reg_e;

  // Glyph sets and special glyph codes
  localparam logic [1:0] SET_SMALL  = 2'd0;
  localparam logic [1:0] SET_LARGE  = 2'd1;
  localparam logic [1:0] SET_LETTER = 2'd2;
  localparam logic [3:0] IDX_COLON  = 4'd10;
  localparam logic [3:0] IDX_SLASH  = 4'd11;
  localparam logic [3:0] IDX_A      = 4'd0;
  localparam logic [3:0] IDX_P      = 4'd1;
  localparam logic [3:0] IDX_M      = 4'd2;

  // Layout spacings
  localparam pix_t SMALL_SPACING  = 14'sd3;
  localparam pix_t LARGE_SPACING  = 14'sd6;
  localparam pix_t ROW_SPACING    = 14'sd40;
  localparam pix_t MARKER_SPACING = 14'sd18;
  localparam int   DATE_GLYPHS    = 10;

  // Divide by ten: x * 52429 >> 19 is exact for any 16-bit x
  localparam logic [16:0] DIV10_RECIP = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // Datapath operation of a microcode step
  typedef enum logic [2:0] {
    OP_WAIT = 3'd0,
    OP_LAY1 = 3'd1,
    OP_LAY2 = 3'd2,
    OP_LAY3 = 3'd3,
    OP_LAY4 = 3'd4,
    OP_EMIT = 3'd5
  } op_e;

  // Glyph index source
  typedef enum logic [3:0] {
    SRC_Y3    = 4'd0,
    SRC_Y2    = 4'd1,
    SRC_Y1    = 4'd2,
    SRC_Y0    = 4'd3,
    SRC_SLASH = 4'd4,
    SRC_MO1   = 4'd5,
    SRC_MO0   = 4'd6,
    SRC_DA1   = 4'd7,
    SRC_DA0   = 4'd8,
    SRC_HR1   = 4'd9,
    SRC_HR0   = 4'd10,
    SRC_COLON = 4'd11,
    SRC_MI1   = 4'd12,
    SRC_MI0   = 4'd13,
    SRC_AP    = 4'd14,
    SRC_LM    = 4'd15
  } src_e;

  typedef enum logic [1:0] {
    Y_ZERO = 2'd0,
    Y_TOP  = 2'd1,
    Y_TIME = 2'd2,
    Y_MARK = 2'd3
  } ysel_e;

  typedef enum logic [2:0] {
    X_HOLD      = 3'd0,
    X_ADD_SMALL = 3'd1,
    X_LOAD_TIME = 3'd2,
    X_ADD_LARGE = 3'd3,
    X_LOAD_MARK = 3'd4,
    X_ADD_MARK  = 3'd5
  } xact_e;

  typedef enum logic [2:0] {
    J_NEXT      = 3'd0,
    J_START     = 3'd1,
    J_ALWAYS    = 3'd2,
    J_SKIP_LEAD = 3'd3,
    J_IF_24     = 3'd4
  } jcond_e;

  // One control word
  typedef struct packed {
    op_e               op;
    logic              glyph;
    logic [1:0]        gset;
    src_e              src;
    ysel_e             ysel;
    xact_e             xact;
    logic              last;
    logic              last24;
    jcond_e            jc;
    logic [STEP_W-1:0] jt;
  } ucw_t;

  localparam logic [STEP_W-1:0] ADDR_WAIT  = 5'd0;
  localparam logic [STEP_W-1:0] ADDR_HR0   = 5'd16;
  localparam logic [STEP_W-1:0] ADDR_EMPTY = 5'd22;

  function automatic ucw_t mk_f(op_e op, logic glyph, logic [1:0] gset, src_e src,
                                ysel_e ysel, xact_e xact, logic last, logic last24,
                                jcond_e jc, logic [STEP_W-1:0] jt);
    ucw_t w;
    w.op     = op;
    w.glyph  = glyph;
    w.gset   = gset;
    w.src    = src;
    w.ysel   = ysel;
    w.xact   = xact;
    w.last   = last;
    w.last24 = last24;
    w.jc     = jc;
    w.jt     = jt;
    return w;
  endfunction

  // Microprogram: four layout steps, ten date glyphs, time digits, marker
  function automatic ucw_t ucode_f(logic [STEP_W-1:0] addr);
    ucw_t w;
    w = mk_f(OP_WAIT, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0, J_ALWAYS,
             ADDR_WAIT);
    case (addr)
      5'd0:  w = mk_f(OP_WAIT, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0,
                      J_START, ADDR_EMPTY);
      5'd1:  w = mk_f(OP_LAY1, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd2:  w = mk_f(OP_LAY2, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd3:  w = mk_f(OP_LAY3, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd4:  w = mk_f(OP_LAY4, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd5:  w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_Y3, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd6:  w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_Y2, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd7:  w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_Y1, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd8:  w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_Y0, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd9:  w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_SLASH, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd10: w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_MO1, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd11: w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_MO0, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd12: w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_SLASH, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd13: w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_DA1, Y_TOP, X_ADD_SMALL, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd14: w = mk_f(OP_EMIT, 1'b1, SET_SMALL, SRC_DA0, Y_TOP, X_LOAD_TIME, 1'b0, 1'b0,
                      J_SKIP_LEAD, ADDR_HR0);
      5'd15: w = mk_f(OP_EMIT, 1'b1, SET_LARGE, SRC_HR1, Y_TIME, X_ADD_LARGE, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd16: w = mk_f(OP_EMIT, 1'b1, SET_LARGE, SRC_HR0, Y_TIME, X_ADD_LARGE, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd17: w = mk_f(OP_EMIT, 1'b1, SET_LARGE, SRC_COLON, Y_TIME, X_ADD_LARGE, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd18: w = mk_f(OP_EMIT, 1'b1, SET_LARGE, SRC_MI1, Y_TIME, X_ADD_LARGE, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd19: w = mk_f(OP_EMIT, 1'b1, SET_LARGE, SRC_MI0, Y_TIME, X_LOAD_MARK, 1'b0, 1'b1,
                      J_IF_24, ADDR_WAIT);
      5'd20: w = mk_f(OP_EMIT, 1'b1, SET_LETTER, SRC_AP, Y_MARK, X_ADD_MARK, 1'b0, 1'b0,
                      J_NEXT, ADDR_WAIT);
      5'd21: w = mk_f(OP_EMIT, 1'b1, SET_LETTER, SRC_LM, Y_MARK, X_HOLD, 1'b1, 1'b0,
                      J_ALWAYS, ADDR_WAIT);
      5'd22: w = mk_f(OP_EMIT, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b1, 1'b0,
                      J_ALWAYS, ADDR_WAIT);
      default: w = mk_f(OP_WAIT, 1'b0, SET_SMALL, SRC_Y3, Y_ZERO, X_HOLD, 1'b0, 1'b0,
                        J_ALWAYS, ADDR_WAIT);
    endcase
    return w;
  endfunction

  // Tens and ones of a value below 64, by a compare chain
  function automatic logic [7:0] tens_ones_f(logic [5:0] v);
    logic [3:0] t;
    logic [5:0] o;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    o = v - (({2'b0, t} << 3) + ({2'b0, t} << 1));
    return {t, o[3:0]};
  endfunction

  function automatic pix_t ext8_f(logic [7:0] v);
    return pix_t'({6'b0, v});
  endfunction

  function automatic pix_t ext11_f(logic [10:0] v);
    return pix_t'({3'b0, v});
  endfunction

  // Halve, truncating toward zero
  function automatic pix_t half_f(pix_t v);
    pix_t t;
    t = v + pix_t'({13'b0, v[13]});
    return t >>> 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/clock_face_glyph_layout.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted item runs layout steps LAY1 to LAY4, then its first emit step loads the
//   output register; an invalid time goes straight to the step that loads the empty result.
// No new item is accepted until the last result of an item is loaded; four layout steps,
//   then one microcode step per glyph, each held while the output register is full.
// Reset: asynchronous, active low; config, step and valid registers reset, sequencer idle.
module clock_face_glyph_layout #(
  parameter int AMPM_GLYPH_WIDTH   = 40,
  parameter int AMPM_GLYPH_HEIGHT  = 48,
  parameter int AMPM_GLYPH_DESCENT = 0
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cfgl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [cfgl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], zero[39:34]
  input  wire logic [39:0]                        s_axis_tdata,
  // time_valid[0]
  input  wire logic                               s_axis_tuser,
  // Output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // glyph_index[3:0], pos_x[15:4], pos_y[27:16], zero[31:28]
  output logic [31:0]                             m_axis_tdata,
  // has_glyph[0], glyph_set[2:1]
  output logic [2:0]                              m_axis_tuser,
  // last_glyph
  output logic                                    m_axis_tlast
);
  import cfgl_pkg::*;

  localparam pix_t MARK_SPAN = pix_t'(2 * AMPM_GLYPH_WIDTH + 3);
  localparam pix_t MARK_STEP = pix_t'(AMPM_GLYPH_WIDTH + 3);
  localparam pix_t MARK_RISE = pix_t'(AMPM_GLYPH_HEIGHT - AMPM_GLYPH_DESCENT);

  // Configuration registers
  logic [10:0] sw_q, sh_q;
  logic        twelve_q;
  logic [7:0]  lw_q, lh_q, ld_q, gw_q, gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= 11'd800;
      sh_q     <= 11'd480;
      twelve_q <= 1'b0;
      lw_q     <= 8'd96;
      lh_q     <= 8'd160;
      ld_q     <= 8'd14;
      gw_q     <= 8'd32;
      gh_q     <= 8'd56;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  sw_q     <= cfg_data_i;
        REG_SCREEN_HEIGHT: sh_q     <= cfg_data_i;
        REG_TWELVE_HOUR:   twelve_q <= cfg_data_i[0];
        REG_LARGE_WIDTH:   lw_q     <= cfg_data_i[7:0];
        REG_LARGE_HEIGHT:  lh_q     <= cfg_data_i[7:0];
        REG_LARGE_DESCENT: ld_q     <= cfg_data_i[7:0];
        REG_SMALL_WIDTH:   gw_q     <= cfg_data_i[7:0];
        REG_SMALL_HEIGHT:  gh_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Sequencer
  logic [STEP_W-1:0] step_q, step_d;
  ucw_t              cw;
  logic              in_xfer, out_free, go, do_emit;

  assign cw            = ucode_f(step_q);
  assign s_axis_tready = (cw.op == OP_WAIT);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign go            = (cw.op == OP_EMIT) ? out_free : 1'b1;
  assign do_emit       = (cw.op == OP_EMIT) && out_free;

  // Input unpacking and small digit splits
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day, in_hour, hr12;
  logic [5:0]  in_minute;
  logic [4:0]  hr_disp;
  logic        skip_in;

  assign in_year   = s_axis_tdata[13:0];
  assign in_month  = s_axis_tdata[17:14];
  assign in_day    = s_axis_tdata[22:18];
  assign in_hour   = s_axis_tdata[27:23];
  assign in_minute = s_axis_tdata[33:28];

  // Twelve-hour reduction: midnight and noon show as 12
  always_comb begin
    if (in_hour >= 5'd24) begin
      hr12 = in_hour - 5'd24;
    end else if (in_hour >= 5'd12) begin
      hr12 = in_hour - 5'd12;
    end else begin
      hr12 = in_hour;
    end
    if (hr12 == 5'd0) begin
      hr12 = 5'd12;
    end
    hr_disp = twelve_q ? hr12 : in_hour;
    skip_in = twelve_q && (hr12 < 5'd10);
  end

  logic [7:0] mo_q, da_q, hr_q, mi_q;
  logic       skip_q, am_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mo_q   <= tens_ones_f({2'b0, in_month});
      da_q   <= tens_ones_f({1'b0, in_day});
      hr_q   <= tens_ones_f({1'b0, hr_disp});
      mi_q   <= tens_ones_f(in_minute);
      skip_q <= skip_in;
      am_q   <= (in_hour < 5'd12);
    end
  end

  // Year digits
  logic [15:0] year_dig;

  cfgl_div10 u_div10 (
    .clk_i    (clk_i),
    .load_i   (in_xfer),
    .step_i   ((cw.op == OP_LAY1) || (cw.op == OP_LAY2) ||
               (cw.op == OP_LAY3) || (cw.op == OP_LAY4)),
    .year_i   (in_year),
    .digits_o (year_dig)
  );

  // Layout datapath, one stage of arithmetic per step
  pix_t ra_q, rb_q, rd_q, dw_q, top_q, time_q, tx_q, mx_q, my_q, x_q;

  always_ff @(posedge clk_i) begin
    case (cw.op)
      OP_LAY1: begin
        ra_q <= ext11_f(sh_q) - (ext8_f(gh_q) + ext8_f(lh_q) + ROW_SPACING);
        rb_q <= ext11_f(sw_q) - (ext8_f(gw_q) * pix_t'(DATE_GLYPHS) +
                                 pix_t'(DATE_GLYPHS - 1) * SMALL_SPACING);
        dw_q <= skip_q ? (ext8_f(lw_q) <<< 2) + pix_t'(3) * LARGE_SPACING
                       : (ext8_f(lw_q) <<< 2) + ext8_f(lw_q) + pix_t'(4) * LARGE_SPACING;
      end
      OP_LAY2: begin
        top_q <= half_f(ra_q);
        rd_q  <= twelve_q ? ext11_f(sw_q) - (dw_q + MARKER_SPACING + MARK_SPAN)
                          : ext11_f(sw_q) - dw_q;
      end
      OP_LAY3: begin
        time_q <= top_q + ext8_f(gh_q) + ROW_SPACING;
        tx_q   <= half_f(rd_q);
      end
      OP_LAY4: begin
        my_q <= am_q ? time_q
                     : time_q + ext8_f(lh_q) - ext8_f(ld_q) - MARK_RISE;
        mx_q <= tx_q + dw_q + MARKER_SPACING;
      end
      default: ;
    endcase
  end

  // Cursor: date start, then stepped or reloaded by each glyph
  always_ff @(posedge clk_i) begin
    if (cw.op == OP_LAY2) begin
      x_q <= half_f(rb_q);
    end else if (do_emit) begin
      case (cw.xact)
        X_ADD_SMALL: x_q <= x_q + ext8_f(gw_q) + SMALL_SPACING;
        X_LOAD_TIME: x_q <= tx_q;
        X_ADD_LARGE: x_q <= x_q + ext8_f(lw_q) + LARGE_SPACING;
        X_LOAD_MARK: x_q <= mx_q;
        X_ADD_MARK:  x_q <= x_q + MARK_STEP;
        default:     x_q <= x_q;
      endcase
    end
  end

  // Glyph index and row selection
  logic [3:0] idx_sel;
  pix_t       y_sel;

  always_comb begin
    case (cw.src)
      SRC_Y3:    idx_sel = year_dig[15:12];
      SRC_Y2:    idx_sel = year_dig[11:8];
      SRC_Y1:    idx_sel = year_dig[7:4];
      SRC_Y0:    idx_sel = year_dig[3:0];
      SRC_SLASH: idx_sel = IDX_SLASH;
      SRC_MO1:   idx_sel = mo_q[7:4];
      SRC_MO0:   idx_sel = mo_q[3:0];
      SRC_DA1:   idx_sel = da_q[7:4];
      SRC_DA0:   idx_sel = da_q[3:0];
      SRC_HR1:   idx_sel = hr_q[7:4];
      SRC_HR0:   idx_sel = hr_q[3:0];
      SRC_COLON: idx_sel = IDX_COLON;
      SRC_MI1:   idx_sel = mi_q[7:4];
      SRC_MI0:   idx_sel = mi_q[3:0];
      SRC_AP:    idx_sel = am_q ? IDX_A : IDX_P;
      SRC_LM:    idx_sel = IDX_M;
      default:   idx_sel = IDX_M;
    endcase
    case (cw.ysel)
      Y_TOP:   y_sel = top_q;
      Y_TIME:  y_sel = time_q;
      Y_MARK:  y_sel = my_q;
      default: y_sel = '0;
    endcase
  end

  // Output register
  logic        m_valid_q;
  logic        has_q, last_q;
  logic [1:0]  set_q;
  logic [3:0]  idx_q;
  logic [11:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (do_emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      has_q  <= cw.glyph;
      set_q  <= cw.glyph ? cw.gset : SET_SMALL;
      idx_q  <= cw.glyph ? idx_sel : 4'd0;
      px_q   <= cw.glyph ? x_q[11:0] : 12'd0;
      py_q   <= y_sel[11:0];
      last_q <= cw.last || (cw.last24 && !twelve_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, py_q, px_q, idx_q};
  assign m_axis_tuser  = {set_q, has_q};
  assign m_axis_tlast  = last_q;

  // Step counter and jumps
  always_comb begin
    step_d = step_q;
    case (cw.jc)
      J_START: begin
        if (in_xfer) begin
          step_d = s_axis_tuser ? step_q + 5'd1 : cw.jt;
        end
      end
      J_NEXT: begin
        if (go) begin
          step_d = step_q + 5'd1;
        end
      end
      J_ALWAYS: begin
        if (go) begin
          step_d = cw.jt;
        end
      end
      J_SKIP_LEAD: begin
        if (go) begin
          step_d = skip_q ? cw.jt : step_q + 5'd1;
        end
      end
      J_IF_24: begin
        if (go) begin
          step_d = !twelve_q ? cw.jt : step_q + 5'd1;
        end
      end
      default: step_d = ADDR_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ADDR_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // An accepted item starts either the layout steps or the empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (step_q == 5'd1) || (step_q == ADDR_EMPTY))
    else $error("sequencer did not start an accepted item");

  // A result is never loaded over one that the sink has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_emit |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten");

  // Loading the final result of an item returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_emit && (cw.last || (cw.last24 && !twelve_q))) |=> step_q == ADDR_WAIT)
    else $error("sequencer busy after final result");

  // An item without a valid time always takes the empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !s_axis_tuser) |=> !cw.glyph && cw.last)
    else $error("invalid time did not take the empty path");

endmodule

`default_nettype wire

>>> rtl/core/cfgl_div10.sv
`timescale 1ns / 1ps
`default_nettype none

// Year digit unit: one divide by ten per step, remainders shifted in from the top,
// so after four steps the thousands digit sits in the top nibble.
module cfgl_div10 (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic        step_i,
  input  wire logic [13:0] year_i,
  output logic      [15:0] digits_o
);
  import cfgl_pkg::*;

  logic [13:0] rem_q;
  logic [15:0] dig_q;
  logic [30:0] prod;
  logic [10:0] quot;
  logic [13:0] back;
  logic [13:0] diff;

  // Reciprocal multiply, then remainder by subtracting ten times the quotient
  always_comb begin
    prod = 31'(rem_q) * 31'(DIV10_RECIP);
    quot = prod[DIV10_SHIFT +: 11];
    back = ({3'b0, quot} << 3) + ({3'b0, quot} << 1);
    diff = rem_q - back;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= year_i;
    end else if (step_i) begin
      rem_q <= {3'b0, quot};
      dig_q <= {diff[3:0], dig_q[15:4]};
    end
  end

  assign digits_o = dig_q;

endmodule

`default_nettype wire
